// File: src/dhc_pkg.sv
// Shared types, constants and constant tables of the depth hillshade colorizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dhc_pkg;

    // Default widths of the depth and weight fields
    localparam int DEPTH_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Palette layout: sea blues below the coast index, land greens from it up
    localparam int PALETTE_SIZE   = 152;
    localparam int PAL_IDX_BITS   = $clog2(PALETTE_SIZE);
    localparam int SEA_TOP_IDX    = 71;
    localparam int LAND_BASE_IDX  = 72;
    localparam int LAND_SPAN_MAX  = PALETTE_SIZE - 1 - LAND_BASE_IDX;
    localparam int CHAN_BITS      = 8;
    localparam int RGB_BITS       = 3 * CHAN_BITS;

    // Height quantization: quotient by 625 through a reciprocal multiply.
    // Inputs are clamped so that the clamped quotient still saturates the index.
    localparam int QUOT_IN_BITS   = 16;
    localparam int QUOT_BITS      = 7;
    localparam int SEA_CLAMP      = 625 * (SEA_TOP_IDX + 1);
    localparam int LAND_CLAMP     = 625 * (LAND_SPAN_MAX + 1);
    localparam int RECIP_625      = 6711;
    localparam int RECIP_625_BITS = 13;
    localparam int RECIP_625_SHIFT = 22;

    // Slope step: k = floor((m + 75) / 150), m = |slope| / 2^(F-2), clamped
    localparam int SLOPE_MAG_BITS = 14;
    localparam int SLOPE_ROUND    = 75;
    localparam int TANH_STEPS     = 56;
    localparam int TANH_IDX_BITS  = $clog2(TANH_STEPS);
    localparam int SLOPE_CLAMP    = 75 * (2 * TANH_STEPS - 1);
    localparam int RECIP_75       = 3496;
    localparam int RECIP_75_BITS  = 12;
    localparam int RECIP_75_SHIFT = 18;

    // Shade factor magnitude, Q1.8
    localparam int TANH_BITS      = 9;
    localparam int TANH_FULL      = 256;

    typedef logic [CHAN_BITS-1:0] tanh_rom_t [TANH_STEPS];

    localparam tanh_rom_t TANH_Q18 = '{
        8'd0,   8'd16,  8'd32,  8'd47,  8'd63,  8'd77,  8'd92,  8'd105,
        8'd118, 8'd131, 8'd142, 8'd153, 8'd163, 8'd172, 8'd180, 8'd188,
        8'd195, 8'd201, 8'd207, 8'd212, 8'd217, 8'd221, 8'd225, 8'd229,
        8'd232, 8'd234, 8'd237, 8'd239, 8'd241, 8'd243, 8'd244, 8'd246,
        8'd247, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd252,
        8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    // Palette entry: blue in the top byte, green in the middle, red at the bottom
    typedef logic [RGB_BITS-1:0] palette_rom_t [PALETTE_SIZE];

    // Build the palette at elaboration; small quotients use exact reciprocals
    function automatic palette_rom_t build_palette();
        palette_rom_t rom;
        int k;
        int r;
        int g;
        int b;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (i < LAND_BASE_IDX) begin
                k = i;
                r = (8 * k * 13108) >> 16;
                g = (10 * k * 21846) >> 16;
                b = 64 + ((8 * k * 21846) >> 16);
            end else begin
                k = i - LAND_BASE_IDX;
                if (k < 20) begin
                    g = k * 4 + 172;
                    r = (64 * k * 13108) >> 16;
                end else if (k < 60) begin
                    g = 255 - (k - 20) * 4;
                    r = 255 - (k - 20) * 2;
                end else begin
                    g = 92 + (k - 60) * 8;
                    r = 172 + (k - 60) * 4;
                end
                b = (k < 60) ? 0 : (k - 60) * 12;
            end
            rom[i] = {CHAN_BITS'(b), CHAN_BITS'(g), CHAN_BITS'(r)};
        end
        return rom;
    endfunction

    localparam palette_rom_t PALETTE = build_palette();

    // Command from the quantizer to the shading stages
    typedef struct packed {
        logic                    vld;
        logic [PAL_IDX_BITS-1:0] idx;
        logic [TANH_BITS-1:0]    t_mag;
        logic                    t_neg;
    } shade_cmd_t;

endpackage

`default_nettype wire

// File: src/depth_hillshade_colorizer_unit.sv
// Depth map pixel colorizer: hypsometric palette tint with tanh hillshade.
// Each transfer carries the four corner depths of a cell and the pixel's x and
// y weights; one RGB transfer comes out per input transfer, in order. The
// datapath is a six-stage pipeline (row blend, height and slope magnitude,
// quotient prep, index and shade factor, palette read, channel blend) and
// takes one pixel per clock while the output does not stall. A stall on
// the output holds every stage through one common enable, and s_tready is
// that enable, with no internal buffering. No configuration.
// Depends on dhc_pkg, dhc_interp, dhc_quant and dhc_shade.
`default_nettype none

module depth_hillshade_colorizer_unit #(
    parameter int DEPTH_BITS = dhc_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = dhc_pkg::FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // depth_top_left, depth_top_right, depth_bottom_left, depth_bottom_right,
    // frac_x, frac_y (lowest bits first), zero padded to whole bytes
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [((4*DEPTH_BITS+2*(FRAC_BITS+1)+7)/8)*8-1:0] s_tdata,
    // red, green, blue (lowest bits first)
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    output logic [dhc_pkg::RGB_BITS-1:0]                    m_tdata
);

    localparam int HW     = DEPTH_BITS + 2 * FRAC_BITS + 2;
    localparam int FW     = FRAC_BITS + 1;
    localparam int OFF_FX = 4 * DEPTH_BITS;
    localparam int OFF_FY = OFF_FX + FW;

    // Advance the whole pipeline unless a result is stuck at the output
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                                   v2;
    logic signed [HW-1:0]                   height;
    logic [dhc_pkg::SLOPE_MAG_BITS-1:0]     slope_mag;
    logic                                   slope_neg;
    dhc_pkg::shade_cmd_t                    cmd;

    dhc_interp #(
        .DEPTH_BITS (DEPTH_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_interp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (en),
        .in_vld             (s_tvalid),
        .depth_top_left     (s_tdata[0 +: DEPTH_BITS]),
        .depth_top_right    (s_tdata[DEPTH_BITS +: DEPTH_BITS]),
        .depth_bottom_left  (s_tdata[2*DEPTH_BITS +: DEPTH_BITS]),
        .depth_bottom_right (s_tdata[3*DEPTH_BITS +: DEPTH_BITS]),
        .frac_x             (s_tdata[OFF_FX +: FW]),
        .frac_y             (s_tdata[OFF_FY +: FW]),
        .out_vld            (v2),
        .height             (height),
        .slope_mag          (slope_mag),
        .slope_neg          (slope_neg)
    );

    dhc_quant #(
        .DEPTH_BITS (DEPTH_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_quant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (v2),
        .height    (height),
        .slope_mag (slope_mag),
        .slope_neg (slope_neg),
        .cmd       (cmd)
    );

    dhc_shade u_shade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cmd     (cmd),
        .out_vld (m_tvalid),
        .rgb     (m_tdata)
    );

    // An accepted transfer reaches the output if every stage keeps advancing
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 s_tready ##1 s_tready ##1 s_tready
        ##1 s_tready ##1 s_tready |=> m_tvalid)
        else $error("accepted transfer lost in pipeline");

endmodule

`default_nettype wire

// File: src/dhc_interp.sv
// Bilinear interpolation of height and slope sum over one cell (two stages).
// Depends on dhc_pkg for default widths and the slope clamp.
`default_nettype none

module dhc_interp #(
    parameter int DEPTH_BITS = dhc_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = dhc_pkg::FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_vld,
    input  logic signed [DEPTH_BITS-1:0]            depth_top_left,
    input  logic signed [DEPTH_BITS-1:0]            depth_top_right,
    input  logic signed [DEPTH_BITS-1:0]            depth_bottom_left,
    input  logic signed [DEPTH_BITS-1:0]            depth_bottom_right,
    input  logic        [FRAC_BITS:0]               frac_x,
    input  logic        [FRAC_BITS:0]               frac_y,
    output logic                                    out_vld,
    output logic signed [DEPTH_BITS+2*FRAC_BITS+1:0] height,
    output logic        [dhc_pkg::SLOPE_MAG_BITS-1:0] slope_mag,
    output logic                                    slope_neg
);

    localparam int RW  = DEPTH_BITS + FRAC_BITS + 1;
    localparam int PW  = DEPTH_BITS + FRAC_BITS + 2;
    localparam int SW  = DEPTH_BITS + FRAC_BITS + 3;
    localparam int HW  = DEPTH_BITS + 2 * FRAC_BITS + 2;
    localparam int HPW = RW + FRAC_BITS + 2;
    localparam int MB  = dhc_pkg::SLOPE_MAG_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Saturate weights above one and form both sides of each weight pair
    logic [FRAC_BITS:0]          fx_sat;
    logic [FRAC_BITS:0]          fy_sat;
    logic signed [FRAC_BITS+1:0] wx0;
    logic signed [FRAC_BITS+1:0] wx1;
    logic signed [FRAC_BITS+1:0] wy0;
    logic signed [FRAC_BITS+1:0] wy1;

    assign fx_sat = (frac_x > ONE) ? ONE : frac_x;
    assign fy_sat = (frac_y > ONE) ? ONE : frac_y;
    assign wx1    = signed'({1'b0, fx_sat});
    assign wx0    = signed'({1'b0, ONE - fx_sat});
    assign wy1    = signed'({1'b0, fy_sat});
    assign wy0    = signed'({1'b0, ONE - fy_sat});

    // Stage 1: blend each row across x
    logic signed [PW-1:0] p_tl;
    logic signed [PW-1:0] p_tr;
    logic signed [PW-1:0] p_bl;
    logic signed [PW-1:0] p_br;
    logic signed [PW-1:0] top_sum;
    logic signed [PW-1:0] bot_sum;

    assign p_tl    = depth_top_left * wx0;
    assign p_tr    = depth_top_right * wx1;
    assign p_bl    = depth_bottom_left * wx0;
    assign p_br    = depth_bottom_right * wx1;
    assign top_sum = p_tl + p_tr;
    assign bot_sum = p_bl + p_br;

    // Stage 1: slope sum from the edge differences
    logic signed [DEPTH_BITS:0] d_h0;
    logic signed [DEPTH_BITS:0] d_h1;
    logic signed [DEPTH_BITS:0] d_v0;
    logic signed [DEPTH_BITS:0] d_v1;
    logic signed [SW-1:0]       q0;
    logic signed [SW-1:0]       q1;
    logic signed [SW-1:0]       q2;
    logic signed [SW-1:0]       q3;
    logic signed [SW-1:0]       slope_next;

    assign d_h0       = depth_top_left - depth_top_right;
    assign d_h1       = depth_bottom_left - depth_bottom_right;
    assign d_v0       = depth_top_left - depth_bottom_left;
    assign d_v1       = depth_top_right - depth_bottom_right;
    assign q0         = d_h0 * wy0;
    assign q1         = d_h1 * wy1;
    assign q2         = d_v0 * wx0;
    assign q3         = d_v1 * wx1;
    assign slope_next = q0 + q1 - q2 - q3;

    logic                        v1_reg;
    logic signed [RW-1:0]        top_reg;
    logic signed [RW-1:0]        bot_reg;
    logic signed [FRAC_BITS+1:0] wy0_reg;
    logic signed [FRAC_BITS+1:0] wy1_reg;
    logic signed [SW-1:0]        slope_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg   <= top_sum[RW-1:0];
            bot_reg   <= bot_sum[RW-1:0];
            wy0_reg   <= wy0;
            wy1_reg   <= wy1;
            slope_reg <= slope_next;
        end
    end

    // Stage 2: blend rows across y and negate to get height
    logic signed [HPW-1:0] ph_top;
    logic signed [HPW-1:0] ph_bot;
    logic signed [HPW-1:0] h_sum;
    logic signed [HPW-1:0] h_neg;

    assign ph_top = top_reg * wy0_reg;
    assign ph_bot = bot_reg * wy1_reg;
    assign h_sum  = ph_top + ph_bot;
    assign h_neg  = -h_sum;

    // Stage 2: slope magnitude in steps of 2^(F-2), clamped past the table end
    logic [SW-1:0] s_abs;
    logic [SW-1:0] s_shift;
    logic [MB-1:0] s_mag_next;

    assign s_abs      = slope_reg[SW-1] ? SW'(-slope_reg) : SW'(slope_reg);
    assign s_shift    = s_abs >> (FRAC_BITS - 2);
    assign s_mag_next = (s_shift > SW'(dhc_pkg::SLOPE_CLAMP)) ?
                        MB'(dhc_pkg::SLOPE_CLAMP) : s_shift[MB-1:0];

    logic                 v2_reg;
    logic signed [HW-1:0] height_reg;
    logic [MB-1:0]        s_mag_reg;
    logic                 s_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            height_reg <= h_neg[HW-1:0];
            s_mag_reg  <= s_mag_next;
            s_neg_reg  <= slope_reg[SW-1];
        end
    end

    assign out_vld   = v2_reg;
    assign height    = height_reg;
    assign slope_mag = s_mag_reg;
    assign slope_neg = s_neg_reg;

endmodule

`default_nettype wire

// File: src/dhc_quant.sv
// Palette index and shade factor from height and slope (two stages).
// Depends on dhc_pkg for reciprocal constants, the tanh table and shade_cmd_t.
`default_nettype none

module dhc_quant #(
    parameter int DEPTH_BITS = dhc_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = dhc_pkg::FRAC_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_vld,
    input  logic signed [DEPTH_BITS+2*FRAC_BITS+1:0] height,
    input  logic        [dhc_pkg::SLOPE_MAG_BITS-1:0] slope_mag,
    input  logic                                     slope_neg,
    output dhc_pkg::shade_cmd_t                      cmd
);

    localparam int HW  = DEPTH_BITS + 2 * FRAC_BITS + 2;
    localparam int QIB = dhc_pkg::QUOT_IN_BITS;
    localparam int QB  = dhc_pkg::QUOT_BITS;
    localparam int QPB = QIB + dhc_pkg::RECIP_625_BITS;
    localparam int MB  = dhc_pkg::SLOPE_MAG_BITS;
    localparam int KB  = dhc_pkg::TANH_IDX_BITS;
    localparam int KPB = (MB - 1) + dhc_pkg::RECIP_75_BITS;
    localparam int IB  = dhc_pkg::PAL_IDX_BITS;
    localparam int TB  = dhc_pkg::TANH_BITS;

    // Stage 3: scale |height| to the quotient input of each branch and clamp
    logic          h_land;
    logic [HW-1:0] h_abs;
    logic [HW+3:0] h_x9;
    logic [HW+3:0] p_sea;
    logic [HW-1:0] p_land;
    logic [QIB-1:0] pc_next;

    assign h_land  = (height > 0);
    assign h_abs   = height[HW-1] ? HW'(-height) : HW'(height);
    assign h_x9    = {h_abs, 3'b000} + (HW+4)'(h_abs);
    assign p_sea   = h_x9 >> (2 * FRAC_BITS + 1);
    assign p_land  = h_abs >> (2 * FRAC_BITS - 4);

    always_comb begin
        if (h_land) begin
            pc_next = (p_land > HW'(dhc_pkg::LAND_CLAMP)) ?
                      QIB'(dhc_pkg::LAND_CLAMP) : p_land[QIB-1:0];
        end else begin
            pc_next = (p_sea > (HW+4)'(dhc_pkg::SEA_CLAMP)) ?
                      QIB'(dhc_pkg::SEA_CLAMP) : p_sea[QIB-1:0];
        end
    end

    // Stage 3: rounded table step, k = floor((m + 75) / 150)
    logic [MB-1:0]  k_num;
    logic [MB-2:0]  k_half;
    logic [KPB-1:0] k_prod;

    assign k_num  = slope_mag + MB'(dhc_pkg::SLOPE_ROUND);
    assign k_half = k_num[MB-1:1];
    assign k_prod = k_half * dhc_pkg::RECIP_75_BITS'(dhc_pkg::RECIP_75);

    logic           v3_reg;
    logic [QIB-1:0] pc_reg;
    logic           land_reg;
    logic [KB-1:0]  k_reg;
    logic           neg3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg   <= pc_next;
            land_reg <= h_land;
            k_reg    <= k_prod[dhc_pkg::RECIP_75_SHIFT +: KB];
            neg3_reg <= slope_neg;
        end
    end

    // Stage 4: quotient by 625, then offset and saturate the palette index
    logic [QPB-1:0] q_prod;
    logic [QB-1:0]  q;
    dhc_pkg::shade_cmd_t cmd_next;
    dhc_pkg::shade_cmd_t cmd_reg;

    assign q_prod = pc_reg * dhc_pkg::RECIP_625_BITS'(dhc_pkg::RECIP_625);
    assign q      = q_prod[dhc_pkg::RECIP_625_SHIFT +: QB];

    always_comb begin
        cmd_next.vld   = v3_reg;
        cmd_next.t_neg = neg3_reg;
        if (land_reg) begin
            cmd_next.idx = (q > QB'(dhc_pkg::LAND_SPAN_MAX)) ?
                           IB'(dhc_pkg::PALETTE_SIZE - 1) :
                           IB'(dhc_pkg::LAND_BASE_IDX) + IB'(q);
        end else begin
            cmd_next.idx = (q > QB'(dhc_pkg::SEA_TOP_IDX)) ?
                           '0 : IB'(dhc_pkg::SEA_TOP_IDX) - IB'(q);
        end
        // Saturate the shade factor past the last table step
        if (k_reg >= KB'(dhc_pkg::TANH_STEPS)) begin
            cmd_next.t_mag = TB'(dhc_pkg::TANH_FULL);
        end else begin
            cmd_next.t_mag = TB'(dhc_pkg::TANH_Q18[k_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg.vld <= 1'b0;
        end else if (en) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

    // Index never leaves the palette, factor never exceeds one
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg.vld |-> (cmd_reg.idx <= IB'(dhc_pkg::PALETTE_SIZE - 1)))
        else $error("palette index out of range");

    a_tanh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg.vld |-> (cmd_reg.t_mag <= TB'(dhc_pkg::TANH_FULL)))
        else $error("shade factor above one");

endmodule

`default_nettype wire

// File: src/dhc_shade.sv
// Palette lookup and hillshade blend toward white or black (two stages).
// Depends on dhc_pkg for the palette table and shade_cmd_t.
`default_nettype none

module dhc_shade (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  dhc_pkg::shade_cmd_t            cmd,
    output logic                           out_vld,
    output logic [dhc_pkg::RGB_BITS-1:0]   rgb
);

    localparam int CB = dhc_pkg::CHAN_BITS;
    localparam int TB = dhc_pkg::TANH_BITS;
    localparam int PB = CB + TB;

    // Stage 5: read the palette
    logic                           v5_reg;
    logic [dhc_pkg::RGB_BITS-1:0]   pal_reg;
    logic [TB-1:0]                  t_mag5_reg;
    logic                           t_neg5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= cmd.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pal_reg    <= dhc_pkg::PALETTE[cmd.idx];
            t_mag5_reg <= cmd.t_mag;
            t_neg5_reg <= cmd.t_neg;
        end
    end

    // Brighten toward full scale (floor) or darken toward zero (ceil)
    function automatic logic [CB-1:0] shade_chan(input logic [CB-1:0] c,
                                                 input logic [TB-1:0] tm,
                                                 input logic neg);
        logic [PB-1:0] up;
        logic [PB-1:0] dn;
        logic [CB-1:0] res;
        up = tm * ({CB{1'b1}} - c);
        dn = tm * c + PB'({CB{1'b1}});
        if (tm == '0) begin
            res = c;
        end else if (!neg) begin
            res = c + up[CB +: CB];
        end else begin
            res = c - dn[CB +: CB];
        end
        return res;
    endfunction

    // Stage 6: blend each channel into the output register
    logic [dhc_pkg::RGB_BITS-1:0] rgb_next;
    logic                         v6_reg;
    logic [dhc_pkg::RGB_BITS-1:0] rgb_reg;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            rgb_next[ch*CB +: CB] = shade_chan(pal_reg[ch*CB +: CB], t_mag5_reg, t_neg5_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_vld = v6_reg;
    assign rgb     = rgb_reg;

    // Brightening never lowers red, darkening never raises blue
    a_brighten: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !t_neg5_reg) |-> (rgb_next[CB-1:0] >= pal_reg[CB-1:0]))
        else $error("brighten lowered red");

    a_darken: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && t_neg5_reg) |-> (rgb_next[2*CB +: CB] <= pal_reg[2*CB +: CB]))
        else $error("darken raised blue");

endmodule

`default_nettype wire

// File: tb/tb_depth_hillshade_colorizer_unit.sv
// Self-checking testbench for depth_hillshade_colorizer_unit: stream bus stimulus,
// an in-order scoreboard with its own pixel color predictor, random idling on both sides.
// Depends on dhc_pkg and the block's RTL only.

module tb_depth_hillshade_colorizer_unit;

    localparam int DEPTH_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int WEIGHT_W   = FRAC_W + 1;
    localparam int WEIGHT_ONE = 1 << FRAC_W;
    localparam int CHAN_W     = dhc_pkg::CHAN_BITS;
    localparam int S_DATA_W   = ((4 * DEPTH_W + 2 * WEIGHT_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_DATA_W - (4 * DEPTH_W + 2 * WEIGHT_W);
    localparam int RAND_ITEMS = 900;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 20;
    localparam int CYCLE_CAP  = 300000;

    // Q1.8 tanh of the slope step, step size 1/16
    localparam int TANH_LUT [56] = '{
        0, 16, 32, 47, 63, 77, 92, 105, 118, 131, 142, 153, 163, 172, 180, 188,
        195, 201, 207, 212, 217, 221, 225, 229, 232, 234, 237, 239, 241, 243, 244, 246,
        247, 248, 249, 250, 250, 251, 252, 252, 253, 253, 253, 254, 254, 254, 254, 255,
        255, 255, 255, 255, 255, 255, 255, 255
    };

    typedef struct {
        logic signed [DEPTH_W-1:0] top_left;
        logic signed [DEPTH_W-1:0] top_right;
        logic signed [DEPTH_W-1:0] bottom_left;
        logic signed [DEPTH_W-1:0] bottom_right;
        logic [WEIGHT_W-1:0]       frac_x;
        logic [WEIGHT_W-1:0]       frac_y;
    } pixel_t;

    typedef struct {
        logic [dhc_pkg::CHAN_BITS-1:0] red;
        logic [dhc_pkg::CHAN_BITS-1:0] green;
        logic [dhc_pkg::CHAN_BITS-1:0] blue;
    } rgb_t;

    // Predict the shaded color of each accepted pixel and check results in order
    class rgb_scoreboard;
        rgb_t expected_rgb [$];
        int   mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        // Palette tint: channel 0 red, 1 green, 2 blue
        function int tint_of(int idx, int chan);
            int k;
            int r;
            int g;
            int b;
            if (idx < 72) begin
                k = idx;
                r = 8 * k / 5;
                g = 20 * k / 6;
                b = 64 + 8 * k / 3;
            end else begin
                k = idx - 72;
                if (k < 20) begin
                    g = k * 4 + 172;
                    r = 64 * k / 5;
                end else if (k < 60) begin
                    g = 255 - (k - 20) * 4;
                    r = 255 - (k - 20) * 2;
                end else begin
                    g = 92 + (k - 60) * 8;
                    r = 172 + (k - 60) * 4;
                end
                b = (k < 60) ? 0 : (k - 60) * 12;
            end
            return (chan == 0 ? r : (chan == 1 ? g : b)) & 255;
        endfunction

        // Brighten toward white or darken toward black by the shade factor
        function int hillshade(int c, int factor);
            if (factor > 0)
                return c + ((factor * (255 - c)) >> 8);
            if (factor < 0)
                return c - ((-factor * c + 255) >> 8);
            return c;
        endfunction

        function rgb_t predict_rgb(pixel_t p);
            longint tl;
            longint tr;
            longint bl;
            longint br;
            longint fx;
            longint fy;
            longint one;
            longint height;
            longint slope;
            longint mag;
            longint quot;
            longint step;
            int     idx;
            int     factor;
            rgb_t   res;
            tl  = p.top_left;
            tr  = p.top_right;
            bl  = p.bottom_left;
            br  = p.bottom_right;
            fx  = (p.frac_x > WEIGHT_ONE) ? WEIGHT_ONE : p.frac_x;
            fy  = (p.frac_y > WEIGHT_ONE) ? WEIGHT_ONE : p.frac_y;
            one = WEIGHT_ONE;
            // height above sea, scaled by one squared
            height = -((tl * (one - fx) + tr * fx) * (one - fy) + (bl * (one - fx) + br * fx) * fy);
            if (height <= 0) begin
                quot = (-height * 9) / (longint'(1250) << (2 * FRAC_W));
                idx  = (quot > 71) ? 0 : 71 - int'(quot);
            end else begin
                quot = (height * 16) / (longint'(625) << (2 * FRAC_W));
                idx  = (quot > 79) ? 151 : 72 + int'(quot);
            end
            // slope sum scaled by one, rounded to a table step
            slope = (tl - tr) * (one - fy) + (bl - br) * fy - (tl - bl) * (one - fx)
                  - (tr - br) * fx;
            mag    = (slope < 0) ? -slope : slope;
            step   = (mag * 32 + (longint'(600) << FRAC_W)) / (longint'(1200) << FRAC_W);
            factor = (step < 56) ? TANH_LUT[step[5:0]] : 256;
            if (slope < 0)
                factor = -factor;
            res.red   = CHAN_W'(hillshade(tint_of(idx, 0), factor));
            res.green = CHAN_W'(hillshade(tint_of(idx, 1), factor));
            res.blue  = CHAN_W'(hillshade(tint_of(idx, 2), factor));
            return res;
        endfunction

        function void note_pixel(pixel_t p);
            expected_rgb.push_back(predict_rgb(p));
        endfunction

        function void check_rgb(logic [dhc_pkg::RGB_BITS-1:0] data);
            rgb_t want;
            rgb_t got;
            got.red   = data[7:0];
            got.green = data[15:8];
            got.blue  = data[23:16];
            if (expected_rgb.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green,
                             got.blue);
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // depth_top_left, depth_top_right, depth_bottom_left, depth_bottom_right,
    // frac_x, frac_y (lowest bits first), zero padded to whole bytes
    logic [S_DATA_W-1:0]           s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // red, green, blue (lowest bits first)
    logic [dhc_pkg::RGB_BITS-1:0]  m_tdata;

    rgb_scoreboard sb = new();
    bit  hold_req = 1'b0;
    int  cycle_count = 0;

    depth_hillshade_colorizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_depth_hillshade_colorizer_unit: errors");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_rgb(m_tdata);
    end

    // Receiver: switch stall patterns now and then, honor one long hold-off
    always @(negedge aclk) begin
        static int mode = 0;
        static int mode_left = 0;
        static int phase = 0;
        static int hold_count = 0;
        phase++;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 4);
            mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        if (hold_req && hold_count < HOLD_LEN) begin
            hold_count++;
            m_tready <= 1'b0;
        end else begin
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 99) < 85);
                3: m_tready <= (phase % 4 != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_pixel(pixel_t p);
        return {{S_PAD_W{1'b0}}, p.frac_y, p.frac_x, p.bottom_right, p.bottom_left,
                p.top_right, p.top_left};
    endfunction

    function automatic pixel_t make_pixel(int tl, int tr, int bl, int br, int fx, int fy);
        pixel_t p;
        p.top_left     = DEPTH_W'(tl);
        p.top_right    = DEPTH_W'(tr);
        p.bottom_left  = DEPTH_W'(bl);
        p.bottom_right = DEPTH_W'(br);
        p.frac_x       = WEIGHT_W'(fx);
        p.frac_y       = WEIGHT_W'(fy);
        return p;
    endfunction

    function automatic int clamp_depth(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int extreme_depth();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Mostly plausible terrain cells around sea level, some full-range noise
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     kind;
        int     base;
        int     spread;
        int     c [4];
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            base = int'($urandom_range(0, 13400)) - 3400;
            case ($urandom_range(0, 2))
                0: spread = $urandom_range(0, 40);
                1: spread = $urandom_range(0, 400);
                default: spread = $urandom_range(0, 2500);
            endcase
            foreach (c[i])
                c[i] = clamp_depth(base + int'($urandom_range(0, 2 * spread)) - spread);
        end else if (kind < 8) begin
            foreach (c[i])
                c[i] = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            foreach (c[i])
                c[i] = extreme_depth();
        end
        p = make_pixel(c[0], c[1], c[2], c[3], 0, 0);
        p.frac_x = WEIGHT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) :
                                                           $urandom_range(0, 256));
        p.frac_y = WEIGHT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) :
                                                           $urandom_range(0, 256));
        return p;
    endfunction

    // Offer one pixel and hold it until the block takes it
    task automatic send_pixel(input pixel_t p);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pixel(p);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_pixel(p);
    endtask

    // Drop valid for a number of cycles, with junk on the data bus
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom(), $urandom(), $urandom()});
            @(posedge aclk);
        end
    endtask

    // Stop sending and wait for every predicted color to come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int sent;
        int burst;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, field extremes, weights above one, coast and palette edges
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(32767, 32767, 32767, 32767, 128, 128));
        send_pixel(make_pixel(-32768, -32768, -32768, -32768, 256, 256));
        send_pixel(make_pixel(1234, -2000, 500, 8000, 511, 257));
        send_pixel(make_pixel(-700, 300, 4000, -1500, 257, 511));
        send_pixel(make_pixel(-1, -1, -1, -1, 255, 1));
        send_pixel(make_pixel(9861, 9861, 9861, 9861, 0, 256));
        send_pixel(make_pixel(9862, 9862, 9862, 9862, 256, 0));
        send_pixel(make_pixel(-3085, -3085, -3085, -3085, 64, 192));
        send_pixel(make_pixel(-3086, -3086, -3086, -3086, 192, 64));
        send_pixel(make_pixel(5000, 5000, 5000, 5000, 100, 200));
        // steep slope, both signs: full white and full black
        send_pixel(make_pixel(32767, -32768, 32767, -32768, 0, 0));
        send_pixel(make_pixel(-32768, 32767, -32768, 32767, 256, 256));
        send_pixel(make_pixel(-32768, 32767, 32767, -32768, 0, 256));
        // gentle slopes around table steps
        send_pixel(make_pixel(0, 18, 0, 18, 128, 128));
        send_pixel(make_pixel(0, -19, 0, -19, 128, 128));
        send_pixel(make_pixel(100, 700, 100, 700, 10, 250));
        send_pixel(make_pixel(-500, -1100, -500, -1100, 250, 10));
        send_pixel(make_pixel(2000, 2000, -2000, -2000, 77, 33));
        send_pixel(make_pixel(-2000, -2000, 2000, 2000, 33, 77));
        send_pixel(make_pixel(32767, 0, -32768, -1, 511, 511));
        send_pixel(make_pixel(-32768, -1, 32767, 0, 1, 1));
        drain_results();

        // Random bursts with random gaps; one long receiver hold, one full drain
        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(1, 32);
            while (burst > 0 && sent < RAND_ITEMS) begin
                if (sent == 300)
                    hold_req = 1'b1;
                if (sent == 600)
                    drain_results();
                send_pixel(random_pixel());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        drain_results();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("tb_depth_hillshade_colorizer_unit: clean");
        else
            $display("tb_depth_hillshade_colorizer_unit: errors");
        $finish;
    end

endmodule
